/* sv/plob_pkg.sv */
// ---------------------------------------------------------------------------
// plob_pkg
// Shared types and constants of the price level order book.
// ---------------------------------------------------------------------------
package plob_pkg;

	localparam int PRICE_LEVELS = 4096;
	localparam int ORDER_SLOTS  = 1024;
	localparam int LVL_W  = 12;                      // level index and best fields
	localparam int SLOT_W = $clog2(ORDER_SLOTS);     // slot address
	localparam int CNT_W  = 11;                      // counts up to ORDER_SLOTS

	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_CANCEL = 1'b1;
	localparam logic SIDE_BID    = 1'b0;
	localparam logic SIDE_ASK    = 1'b1;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_RANGE   = 3'd1,
		ST_DUP     = 3'd2,
		ST_UNKNOWN = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		logic               kind;
		logic [31:0]        order_id;
		logic signed [15:0] price;
		logic               side;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [11:0] best_bid;
		logic [11:0] best_ask;
		logic [10:0] bid_orders;
		logic [10:0] ask_orders;
	} res_t;

	// Classified request handed from front to back
	typedef struct packed {
		logic             kind;
		logic [31:0]      order_id;
		logic [LVL_W-1:0] lvl;
		logic             side;
		logic             range_bad;
	} cmd_t;

	// One order table entry
	typedef struct packed {
		logic [31:0]      order_id;
		logic [LVL_W-1:0] lvl;
		logic             side;
	} slot_t;

endpackage

/* sv/price_level_order_book.sv */
// ---------------------------------------------------------------------------
// price_level_order_book
// Limit order book with per-level counts, side totals and best bid/ask.
// ---------------------------------------------------------------------------
// Each request gives one result. After reset the level count memory is
// cleared level by level, during which no request is taken. A request
// searches the resting orders, since the order table is kept packed in a
// RAM and searched one entry at a time. A cancel that empties a best level
// also scans the level counts, one level at a time, for the next level
// that is not empty. A two entry queue in front takes new requests while
// a request runs or a result waits, until the queue is full.
module price_level_order_book (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  plob_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_stall,
	output plob_pkg::res_t res
);

	logic           cmd_valid;
	plob_pkg::cmd_t cmd;
	logic           cmd_pop;
	logic           clearing;

	plob_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.clearing  (clearing),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	plob_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.clearing  (clearing),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

/* sv/plob_ram.sv */
// ---------------------------------------------------------------------------
// plob_ram
// Generic simple dual port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module plob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/plob_front.sv */
// ---------------------------------------------------------------------------
// plob_front
// Accepts requests, classifies them and holds them in a two entry queue.
// ---------------------------------------------------------------------------
module plob_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  plob_pkg::req_t  req,
	input  logic            clearing,
	output logic            cmd_valid,
	output plob_pkg::cmd_t  cmd,
	input  logic            cmd_pop
);

	plob_pkg::cmd_t ent_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;
	plob_pkg::cmd_t cls;

	// Price range check and level extraction
	always_comb begin
		cls.kind      = req.kind;
		cls.order_id  = req.order_id;
		cls.lvl       = req.price[plob_pkg::LVL_W-1:0];
		cls.side      = req.side;
		cls.range_bad = req.price[15] ||
			({1'b0, req.price} >= 17'(plob_pkg::PRICE_LEVELS));
	end

	assign req_stall = (cnt_q == 2'd2) || clearing;
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= cls;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (cmd_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

/* sv/plob_back.sv */
// ---------------------------------------------------------------------------
// plob_back
// Executes requests: order table search, level count update, best rescan.
// ---------------------------------------------------------------------------
module plob_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  plob_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           clearing,
	output logic           res_valid,
	input  logic           res_stall,
	output plob_pkg::res_t res
);

	localparam int LW = plob_pkg::LVL_W;
	localparam int CW = plob_pkg::CNT_W;
	localparam int SW = plob_pkg::SLOT_W;
	localparam logic [LW-1:0] TOP_LVL = LW'(plob_pkg::PRICE_LEVELS - 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SRD, S_SCMP, S_MVRD, S_MVWR,
		S_LRD, S_LUPD, S_SCRD, S_SCCK, S_DONE
	} state_t;

	state_t            state_q;
	plob_pkg::cmd_t    cmd_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     cnt_q;
	logic [SW-1:0]     found_q;
	logic [LW-1:0]     lvl_q;
	logic              side_q;
	logic [LW-1:0]     scan_q;
	logic [LW-1:0]     clr_q;
	logic [LW-1:0]     best_bid_q;
	logic [LW-1:0]     best_ask_q;
	logic [CW-1:0]     bid_tot_q;
	logic [CW-1:0]     ask_tot_q;
	plob_pkg::status_t stat_q;
	logic              out_valid_q;
	plob_pkg::res_t    out_q;

	logic              slot_we;
	logic [SW-1:0]     slot_waddr;
	plob_pkg::slot_t   slot_wdata;
	logic [SW-1:0]     slot_raddr;
	plob_pkg::slot_t   slot_rdata;
	logic              lvl_we;
	logic [LW-1:0]     lvl_waddr;
	logic [CW-1:0]     lvl_wdata;
	logic [LW-1:0]     lvl_raddr;
	logic [CW-1:0]     lvl_rdata;
	logic [CW-1:0]     lvl_dec;
	logic              start;

	plob_ram #(.WIDTH($bits(plob_pkg::slot_t)), .DEPTH(plob_pkg::ORDER_SLOTS)) u_slot (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	plob_ram #(.WIDTH(CW), .DEPTH(plob_pkg::PRICE_LEVELS)) u_level (
		.clk   (clk),
		.we    (lvl_we),
		.waddr (lvl_waddr),
		.wdata (lvl_wdata),
		.raddr (lvl_raddr),
		.rdata (lvl_rdata)
	);

	assign start     = (state_q == S_IDLE) && cmd_valid && !out_valid_q;
	assign cmd_pop   = start;
	assign clearing  = (state_q == S_CLEAR);
	assign res_valid = out_valid_q;
	assign res       = out_q;
	assign lvl_dec   = (lvl_rdata != '0) ? lvl_rdata - CW'(1) : '0;

	// Memory port control
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = cnt_q[SW-1:0];
		slot_wdata = {cmd_q.order_id, cmd_q.lvl, cmd_q.side};
		slot_raddr = idx_q[SW-1:0];
		lvl_we     = 1'b0;
		lvl_waddr  = lvl_q;
		lvl_wdata  = lvl_rdata + CW'(1);
		lvl_raddr  = lvl_q;
		case (state_q)
			S_CLEAR: begin
				lvl_we    = 1'b1;
				lvl_waddr = clr_q;
				lvl_wdata = '0;
			end
			S_SRD: begin
				// append a new order at the end of the packed table
				slot_we = (idx_q == cnt_q) && (cmd_q.kind == plob_pkg::KIND_ADD) &&
					(cnt_q != CW'(plob_pkg::ORDER_SLOTS));
			end
			S_MVRD: begin
				slot_raddr = cnt_q[SW-1:0];
			end
			S_MVWR: begin
				// last entry fills the freed slot
				slot_we    = 1'b1;
				slot_waddr = found_q;
				slot_wdata = slot_rdata;
			end
			S_LUPD: begin
				lvl_we = 1'b1;
				if (cmd_q.kind == plob_pkg::KIND_CANCEL) begin
					lvl_wdata = lvl_dec;
				end
			end
			S_SCRD: begin
				lvl_raddr = scan_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			best_bid_q  <= '0;
			best_ask_q  <= TOP_LVL;
			bid_tot_q   <= '0;
			ask_tot_q   <= '0;
			stat_q      <= plob_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !res_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + LW'(1);
					if (clr_q == TOP_LVL) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						idx_q <= '0;
						if (cmd.kind == plob_pkg::KIND_ADD && cmd.range_bad) begin
							stat_q  <= plob_pkg::ST_RANGE;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SRD;
						end
					end
				end
				S_SRD: begin
					if (idx_q == cnt_q) begin
						// id not present
						if (cmd_q.kind == plob_pkg::KIND_CANCEL) begin
							stat_q  <= plob_pkg::ST_UNKNOWN;
							state_q <= S_DONE;
						end else if (cnt_q == CW'(plob_pkg::ORDER_SLOTS)) begin
							stat_q  <= plob_pkg::ST_FULL;
							state_q <= S_DONE;
						end else begin
							cnt_q   <= cnt_q + CW'(1);
							lvl_q   <= cmd_q.lvl;
							side_q  <= cmd_q.side;
							state_q <= S_LRD;
						end
					end else begin
						state_q <= S_SCMP;
					end
				end
				S_SCMP: begin
					if (slot_rdata.order_id == cmd_q.order_id) begin
						if (cmd_q.kind == plob_pkg::KIND_ADD) begin
							stat_q  <= plob_pkg::ST_DUP;
							state_q <= S_DONE;
						end else begin
							lvl_q   <= slot_rdata.lvl;
							side_q  <= slot_rdata.side;
							found_q <= idx_q[SW-1:0];
							cnt_q   <= cnt_q - CW'(1);
							state_q <= (idx_q == cnt_q - CW'(1)) ? S_LRD : S_MVRD;
						end
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SRD;
					end
				end
				S_MVRD: begin
					state_q <= S_MVWR;
				end
				S_MVWR: begin
					state_q <= S_LRD;
				end
				S_LRD: begin
					state_q <= S_LUPD;
				end
				S_LUPD: begin
					stat_q  <= plob_pkg::ST_OK;
					state_q <= S_DONE;
					if (cmd_q.kind == plob_pkg::KIND_ADD) begin
						if (side_q == plob_pkg::SIDE_BID) begin
							bid_tot_q <= bid_tot_q + CW'(1);
							if (bid_tot_q == '0 || lvl_q > best_bid_q) begin
								best_bid_q <= lvl_q;
							end
						end else begin
							ask_tot_q <= ask_tot_q + CW'(1);
							if (ask_tot_q == '0 || lvl_q < best_ask_q) begin
								best_ask_q <= lvl_q;
							end
						end
					end else if (side_q == plob_pkg::SIDE_BID) begin
						if (bid_tot_q != '0) begin
							bid_tot_q <= bid_tot_q - CW'(1);
						end
						// emptied best bid level
						if (lvl_dec == '0 && lvl_q == best_bid_q) begin
							if (bid_tot_q <= CW'(1)) begin
								best_bid_q <= '0;
							end else if (lvl_q != '0) begin
								scan_q  <= lvl_q - LW'(1);
								state_q <= S_SCRD;
							end
						end
					end else begin
						if (ask_tot_q != '0) begin
							ask_tot_q <= ask_tot_q - CW'(1);
						end
						// emptied best ask level
						if (lvl_dec == '0 && lvl_q == best_ask_q) begin
							if (ask_tot_q <= CW'(1)) begin
								best_ask_q <= TOP_LVL;
							end else if (lvl_q != TOP_LVL) begin
								scan_q  <= lvl_q + LW'(1);
								state_q <= S_SCRD;
							end
						end
					end
				end
				S_SCRD: begin
					state_q <= S_SCCK;
				end
				S_SCCK: begin
					// one level per visit, down for bids, up for asks
					if (lvl_rdata != '0) begin
						if (side_q == plob_pkg::SIDE_BID) begin
							best_bid_q <= scan_q;
						end else begin
							best_ask_q <= scan_q;
						end
						state_q <= S_DONE;
					end else if (side_q == plob_pkg::SIDE_BID) begin
						if (scan_q == '0) begin
							state_q <= S_DONE;
						end else begin
							scan_q  <= scan_q - LW'(1);
							state_q <= S_SCRD;
						end
					end else begin
						if (scan_q == TOP_LVL) begin
							state_q <= S_DONE;
						end else begin
							scan_q  <= scan_q + LW'(1);
							state_q <= S_SCRD;
						end
					end
				end
				S_DONE: begin
					out_q.status     <= stat_q;
					out_q.best_bid   <= best_bid_q;
					out_q.best_ask   <= best_ask_q;
					out_q.bid_orders <= bid_tot_q;
					out_q.ask_orders <= ask_tot_q;
					out_valid_q      <= 1'b1;
					state_q          <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
